// File: hw/rtl/chorus_pkg.sv
package chorus_pkg;

	localparam int HISTORY_DEPTH_DEF   = 8192;
	localparam int SAMPLE_BITS_DEF     = 24;
	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LFO_PHASE_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAIN         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_INTENSITY = 3'd5;

	localparam int             POS_W     = 13;
	localparam logic [POS_W-1:0] POS_MAX = 13'h1FFF;
	localparam int             DELAY_W   = 13;
	localparam logic [DELAY_W-1:0] DELAY_LIMIT = 13'd8190;

	localparam int          SINE_MAG_W = 15;
	localparam logic [16:0] GAIN_ONE   = 17'd32768;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint COEF_1  = 64'sd1686629713;
	localparam longint COEF_3  = 64'sd693598669;
	localparam longint COEF_5  = 64'sd85569306;
	localparam longint COEF_7  = 64'sd5026994;
	localparam longint COEF_9  = 64'sd172273;

	typedef struct packed {
		logic tap_en;
		logic wet_en;
		logic hit;
	} mix_ctrl_t;

	// Quarter-wave sine entry, Q2.30 Horner on the odd Taylor series, rounded to unsigned Q0.15.
	function automatic logic [SINE_MAG_W-1:0] sine_entry(input int k, input int tb);
		longint u;
		longint u2;
		longint acc;
		longint r;
		u   = (longint'(k) <<< 30) >>> tb;
		u2  = (u * u) / Q30_ONE;
		acc = COEF_9;
		acc = (acc * u2) / Q30_ONE - COEF_7;
		acc = (acc * u2) / Q30_ONE + COEF_5;
		acc = (acc * u2) / Q30_ONE - COEF_3;
		acc = (acc * u2) / Q30_ONE + COEF_1;
		r   = (acc * u) / Q30_ONE;
		if (r < 0) begin
			r = 0;
		end
		r = (r + 64'sd16384) >>> 15;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end
		return SINE_MAG_W'(r);
	endfunction

endpackage

// File: hw/rtl/chorus_sine_rom.sv
module chorus_sine_rom #(
	parameter int SINE_TABLE_BITS = chorus_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic [SINE_TABLE_BITS:0]              addr,
	output logic [chorus_pkg::SINE_MAG_W-1:0]     data
);
	import chorus_pkg::*;

	localparam int ROM_N = (1 << SINE_TABLE_BITS) + 1;

	typedef logic [SINE_MAG_W-1:0] rom_t [0:ROM_N-1];

	function automatic rom_t build_rom();
		rom_t t;
		for (int k = 0; k < ROM_N; k++) begin
			t[k] = sine_entry(k, SINE_TABLE_BITS);
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [SINE_MAG_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

// File: hw/rtl/chorus_ring.sv
module chorus_ring #(
	parameter int HISTORY_DEPTH = chorus_pkg::HISTORY_DEPTH_DEF,
	parameter int SAMPLE_BITS   = chorus_pkg::SAMPLE_BITS_DEF,
	localparam int ADDR_W       = $clog2(HISTORY_DEPTH)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [ADDR_W-1:0]      waddr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	input  logic                   re,
	input  logic [ADDR_W-1:0]      raddr,
	output logic [SAMPLE_BITS-1:0] rdata
);
	import chorus_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [0:HISTORY_DEPTH-1];
	logic [SAMPLE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/chorus_mix.sv
module chorus_mix #(
	parameter int SAMPLE_BITS = chorus_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  chorus_pkg::mix_ctrl_t         ctrl,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [SAMPLE_BITS-1:0] tap,
	input  logic signed [15:0]            tap_gain,
	input  logic [15:0]                   wet_mix,
	input  logic [15:0]                   effect_intensity,
	output logic signed [SAMPLE_BITS-1:0] y
);
	import chorus_pkg::*;

	localparam int GM_W  = 34;
	localparam int P_W   = GM_W + SAMPLE_BITS;
	localparam int D1_W  = P_W - 15;
	localparam int E_W   = D1_W + 18;
	localparam int R_W   = E_W - 30;
	localparam int SUM_W = R_W + 1;

	localparam logic signed [P_W-1:0]   P_HALF = P_W'(16384);
	localparam logic signed [E_W-1:0]   E_HALF = E_W'(64'sd536870912);
	localparam logic signed [SUM_W-1:0] Y_MAX  = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] Y_MIN  = SUM_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	logic [16:0]              wet_c;
	logic [16:0]              inten_c;
	logic signed [GM_W-1:0]   gm;
	logic signed [GM_W-1:0]   gm_q;
	logic signed [P_W-1:0]    p_q;
	logic signed [P_W-1:0]    p_rnd;
	logic signed [D1_W-1:0]   d1;
	logic signed [E_W-1:0]    e_q;
	logic signed [E_W-1:0]    e_rnd;
	logic signed [R_W-1:0]    r;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sat;

	assign wet_c   = (wet_mix > 16'd32768) ? GAIN_ONE : {1'b0, wet_mix};
	assign inten_c = (effect_intensity > 16'd32768) ? GAIN_ONE : {1'b0, effect_intensity};
	assign gm      = $signed({1'b0, wet_c}) * tap_gain;

	always_ff @(posedge clk) begin
		gm_q <= gm;
		if (ctrl.tap_en) begin
			p_q <= gm_q * tap;
		end
		if (ctrl.wet_en) begin
			e_q <= $signed({1'b0, inten_c}) * d1;
		end
	end

	assign p_rnd = p_q + P_HALF;
	assign d1    = p_rnd[P_W-1:15];
	assign e_rnd = e_q + E_HALF;
	assign r     = e_rnd[E_W-1:30];
	assign sum   = SUM_W'(x) + SUM_W'(r);

	always_comb begin
		if (sum > Y_MAX) begin
			sat = Y_MAX;
		end else if (sum < Y_MIN) begin
			sat = Y_MIN;
		end else begin
			sat = sum;
		end
	end

	assign y = ctrl.hit ? sat[SAMPLE_BITS-1:0] : x;

endmodule

// File: hw/rtl/chorus_modulated_delay.sv
// Chorus, one channel: a sequencer walks each sample through the sine ROM read, the depth and
// delay multiplies, the history ring read and the two gain multiplies, and takes no new sample
// until it is back in idle; a full, stalled output register holds it in ST_OUT. The history
// ring is a single-port-write, registered-read memory of HISTORY_DEPTH samples (a power of
// two); it needs no clearing after reset. The result sits in an output register, so the
// next sample is taken while a finished one still waits. Configuration writes belong to idle
// periods only. block_start restarts the LFO phase and the block position for that sample.
module chorus_modulated_delay #(
	parameter int HISTORY_DEPTH   = chorus_pkg::HISTORY_DEPTH_DEF,
	parameter int SAMPLE_BITS     = chorus_pkg::SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = chorus_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [chorus_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [chorus_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  logic                                block_start,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample_out
);
	import chorus_pkg::*;

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int PH_W   = SINE_TABLE_BITS + 2;
	localparam logic [SINE_TABLE_BITS:0] ROM_Q = (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROM,
		ST_MOD,
		ST_SCALE,
		ST_ADDR,
		ST_TAP,
		ST_WET,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	logic [11:0]        base_delay_q;
	logic [31:0]        lfo_phase_step_q;
	logic [15:0]        mod_depth_q;
	logic signed [15:0] tap_gain_q;
	logic [15:0]        wet_mix_q;
	logic [15:0]        effect_intensity_q;

	logic [ADDR_W-1:0] wp_q;
	logic [POS_W-1:0]  pos_q;
	logic [31:0]       phase_q;

	logic [ADDR_W-1:0]             wp_use_q;
	logic [POS_W-1:0]              pos_use_q;
	logic [PH_W-1:0]               ph_use_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [32:0]            m_q;
	logic [43:0]                   dq_q;
	logic                          hit_q;

	logic                           in_fire;
	logic                           out_load;
	logic [POS_W-1:0]               pos_eff;
	logic [31:0]                    phase_eff;
	logic [SINE_TABLE_BITS-1:0]     rom_idx;
	logic [SINE_TABLE_BITS:0]       rom_addr;
	logic [SINE_MAG_W-1:0]          rom_data;
	logic signed [15:0]             sine;
	logic signed [32:0]             m;
	logic [31:0]                    offs;
	logic [43:0]                    dq_rnd;
	logic [DELAY_W-1:0]             delay;
	logic [ADDR_W-1:0]              raddr;
	logic signed [SAMPLE_BITS-1:0]  tap;
	logic signed [SAMPLE_BITS-1:0]  y;
	mix_ctrl_t                      mix_ctrl;

	assign in_fire   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign pos_eff   = block_start ? '0 : pos_q;
	assign phase_eff = block_start ? 32'd0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_delay_q       <= '0;
			lfo_phase_step_q   <= '0;
			mod_depth_q        <= '0;
			tap_gain_q         <= '0;
			wet_mix_q          <= '0;
			effect_intensity_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_DELAY:       base_delay_q       <= cfg_data[11:0];
				CFG_LFO_PHASE_STEP:   lfo_phase_step_q   <= cfg_data[31:0];
				CFG_MOD_DEPTH:        mod_depth_q        <= cfg_data[15:0];
				CFG_TAP_GAIN:         tap_gain_q         <= $signed(cfg_data[15:0]);
				CFG_WET_MIX:          wet_mix_q          <= cfg_data[15:0];
				CFG_EFFECT_INTENSITY: effect_intensity_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			pos_q   <= '0;
			phase_q <= '0;
		end else if (in_fire) begin
			wp_q    <= wp_q + 1'b1;
			pos_q   <= (pos_eff == POS_MAX) ? pos_eff : pos_eff + 1'b1;
			phase_q <= phase_eff + lfo_phase_step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				sample_out_q <= y;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (in_fire) begin
					state_q <= ST_ROM;
				end
				ST_ROM:   state_q <= ST_MOD;
				ST_MOD:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_ADDR;
				ST_ADDR:  state_q <= ST_TAP;
				ST_TAP:   state_q <= ST_WET;
				ST_WET:   state_q <= ST_OUT;
				ST_OUT:   if (out_load) begin
					state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			wp_use_q  <= wp_q;
			pos_use_q <= pos_eff;
			ph_use_q  <= phase_eff[31 -: PH_W];
			x_q       <= sample_in;
		end
		if (state_q == ST_MOD) begin
			m_q <= m;
		end
		if (state_q == ST_SCALE) begin
			dq_q <= base_delay_q * offs;
		end
		if (state_q == ST_ADDR) begin
			hit_q <= (delay <= pos_use_q);
		end
	end

	// quarter-wave fold: odd quadrants mirror the index, upper half negates
	assign rom_idx  = ph_use_q[SINE_TABLE_BITS-1:0];
	assign rom_addr = ph_use_q[SINE_TABLE_BITS] ? (ROM_Q - {1'b0, rom_idx}) : {1'b0, rom_idx};
	assign sine     = ph_use_q[SINE_TABLE_BITS+1] ? -$signed({1'b0, rom_data})
		: $signed({1'b0, rom_data});
	assign m        = $signed({1'b0, mod_depth_q}) * sine;
	assign offs     = 32'h8000_0000 + m_q[31:0];
	assign dq_rnd   = dq_q + 44'h0_4000_0000;
	assign delay    = dq_rnd[43:31];
	assign raddr    = wp_use_q - ADDR_W'(delay);

	assign mix_ctrl.tap_en = (state_q == ST_TAP);
	assign mix_ctrl.wet_en = (state_q == ST_WET);
	assign mix_ctrl.hit    = hit_q;

	chorus_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_sine_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	chorus_ring #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_ring (
		.clk  (clk),
		.we   (in_fire),
		.waddr(wp_q),
		.wdata(sample_in),
		.re   (state_q == ST_ADDR),
		.raddr(raddr),
		.rdata(tap)
	);

	chorus_mix #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mix (
		.clk             (clk),
		.ctrl            (mix_ctrl),
		.x               (x_q),
		.tap             (tap),
		.tap_gain        (tap_gain_q),
		.wet_mix         (wet_mix_q),
		.effect_intensity(effect_intensity_q),
		.y               (y)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> in_stall)
		else $error("sequencer idle right after a transaction");

	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> wp_q == $past(wp_q) + 1'b1)
		else $error("write pointer did not advance by one");

	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADDR |-> delay <= DELAY_LIMIT)
		else $error("delay out of range");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result shown without a finished sample");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_valid_q && out_stall |=> state_q == ST_OUT)
		else $error("result dropped while output register full");

endmodule

// File: tb/sv/chorus_modulated_delay_test.sv
`timescale 1ns / 1ps

module chorus_modulated_delay_test;
	import chorus_pkg::*;

	localparam int RING_SIZE = 8192;
	localparam int ROM_STEPS = 1024;
	localparam longint Q30 = 64'sd1073741824;
	localparam longint C1 = 64'sd1686629713;
	localparam longint C3 = 64'sd693598669;
	localparam longint C5 = 64'sd85569306;
	localparam longint C7 = 64'sd5026994;
	localparam longint C9 = 64'sd172273;
	localparam longint OUT_MAX = 64'sd8388607;
	localparam longint OUT_MIN = -64'sd8388608;

	class chorus_scoreboard;
		logic [23:0] history [RING_SIZE];
		bit [12:0] wr_ptr;
		bit [12:0] blk_pos;
		bit [31:0] lfo_acc;
		bit [11:0] base_dly;
		bit [31:0] phase_inc;
		bit [15:0] depth;
		logic signed [15:0] tap_gain_q;
		bit [15:0] wet_q;
		bit [15:0] inten_q;
		int quarter_wave [ROM_STEPS + 1];
		logic signed [23:0] expected_out [$];
		int errors;
		int n_in;
		int n_out;
		int n_wet;
		int n_early;
		int n_sat;
		int n_wrap;
		int max_dly;

		function new();
			longint u;
			longint u2;
			longint h;
			longint r;
			for (int k = 0; k <= ROM_STEPS; k++) begin
				u = (longint'(k) << 30) / ROM_STEPS;
				u2 = u * u / Q30;
				h = C9;
				h = h * u2 / Q30 - C7;
				h = h * u2 / Q30 + C5;
				h = h * u2 / Q30 - C3;
				h = h * u2 / Q30 + C1;
				r = h * u / Q30;
				if (r < 0) begin
					r = 0;
				end
				r = (r + 64'sd16384) >>> 15;
				quarter_wave[k] = (r > 64'sd32767) ? 32767 : int'(r);
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
			case (idx)
			CFG_BASE_DELAY: base_dly = v[11:0];
			CFG_LFO_PHASE_STEP: phase_inc = v;
			CFG_MOD_DEPTH: depth = v[15:0];
			CFG_TAP_GAIN: tap_gain_q = v[15:0];
			CFG_WET_MIX: wet_q = v[15:0];
			CFG_EFFECT_INTENSITY: inten_q = v[15:0];
			default: ;
			endcase
		endfunction

		function longint lfo_value(bit [31:0] ph);
			longint v;
			v = ph[30] ? quarter_wave[ROM_STEPS - int'(ph[29:20])] : quarter_wave[ph[29:20]];
			return ph[31] ? -v : v;
		endfunction

		function void note_input(logic signed [23:0] x, bit bs);
			longint mod_prod;
			longint scaled;
			longint dly;
			longint tap;
			longint mix;
			longint inten;
			longint d1;
			longint y;
			bit [12:0] addr;
			if (bs) begin
				lfo_acc = '0;
				blk_pos = '0;
			end
			mod_prod = longint'(depth) * lfo_value(lfo_acc);
			scaled = longint'(base_dly) * ((64'sd1 <<< 31) + mod_prod);
			dly = (scaled + (64'sd1 <<< 30)) >>> 31;
			history[wr_ptr] = x;
			y = x;
			if (dly >= 0 && dly <= longint'(blk_pos)) begin
				addr = wr_ptr - 13'(dly);
				if (dly > longint'(wr_ptr)) begin
					n_wrap++;
				end
				if (dly > max_dly) begin
					max_dly = int'(dly);
				end
				tap = longint'($signed(history[addr]));
				mix = (wet_q > 16'd32768) ? 64'sd32768 : longint'(wet_q);
				inten = (inten_q > 16'd32768) ? 64'sd32768 : longint'(inten_q);
				d1 = (mix * (longint'(tap_gain_q) * tap) + (64'sd1 <<< 14)) >>> 15;
				y = longint'(x) + ((inten * d1 + (64'sd1 <<< 29)) >>> 30);
				n_wet++;
				if (y > OUT_MAX) begin
					y = OUT_MAX;
					n_sat++;
				end else if (y < OUT_MIN) begin
					y = OUT_MIN;
					n_sat++;
				end
			end else begin
				n_early++;
			end
			expected_out.push_back(y[23:0]);
			wr_ptr++;
			if (blk_pos != 13'h1FFF) begin
				blk_pos++;
			end
			lfo_acc += phase_inc;
			n_in++;
		endfunction

		task report(string what);
			errors++;
			$display("mismatch %0d: %s", errors, what);
		endtask

		task check_output(logic signed [23:0] got);
			logic signed [23:0] want;
			if (expected_out.size() == 0) begin
				report($sformatf("sample_out %0d with no transaction pending", got));
			end else begin
				want = expected_out.pop_front();
				n_out++;
				if (got !== want) begin
					report($sformatf("transaction %0d: sample_out %0d, want %0d", n_out, got, want));
				end
			end
		endtask

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [23:0] sample_in;
	logic block_start;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [23:0] sample_out;

	chorus_scoreboard sb = new();
	int stall_mode = 0;
	int stall_left = 0;
	int gap_max = 0;
	int burst_left = 0;
	int n_settings = 0;

	chorus_modulated_delay u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.block_start(block_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(15_000_000);
		$display("timeout with %0d transactions outstanding", sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (stall_mode == 0) begin
			out_stall <= 1'b0;
		end else if (stall_mode == 2) begin
			out_stall <= ($urandom_range(0, 2) == 0);
		end else if (stall_left == 0) begin
			out_stall <= !out_stall;
			stall_left <= out_stall ? $urandom_range(2, 14) : $urandom_range(1, 10);
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			sb.check_output(sample_out);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic load_settings(bit [11:0] b, bit [31:0] st, bit [15:0] dp, logic [15:0] g,
			bit [15:0] mx, bit [15:0] it);
		write_reg(CFG_BASE_DELAY, {20'h0, b});
		write_reg(CFG_LFO_PHASE_STEP, st);
		write_reg(CFG_MOD_DEPTH, {16'h0, dp});
		write_reg(CFG_TAP_GAIN, {16'h0, g});
		write_reg(CFG_WET_MIX, {16'h0, mx});
		write_reg(CFG_EFFECT_INTENSITY, {16'h0, it});
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic send_sample(logic signed [23:0] x, bit bs);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_in <= x;
		block_start <= bs;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_input(x, bs);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 11))
		0: return 24'sh7FFFFF;
		1: return 24'sh800000;
		2: return '0;
		3: return '1;
		default: return 24'($urandom);
		endcase
	endfunction

	function automatic bit [15:0] pick_blend();
		case ($urandom_range(0, 5))
		0: return 16'd0;
		1: return 16'd32768;
		2: return 16'hFFFF;
		3: return 16'($urandom);
		default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic random_settings();
		bit [11:0] b;
		bit [31:0] st;
		bit [15:0] dp;
		logic [15:0] g;
		case ($urandom_range(0, 5))
		0: b = 12'd0;
		1: b = 12'hFFF;
		2, 3: b = 12'($urandom_range(1, 24));
		default: b = 12'($urandom_range(25, 300));
		endcase
		case ($urandom_range(0, 4))
		0: st = 32'h0;
		1: st = 32'hFFFF_FFFF;
		2: st = 32'h4000_0000;
		3: st = $urandom;
		default: st = 32'($urandom_range(1, 1 << 26));
		endcase
		case ($urandom_range(0, 3))
		0: dp = 16'h0;
		1: dp = 16'hFFFF;
		default: dp = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
		0: g = 16'h8000;
		1: g = 16'h7FFF;
		default: g = 16'($urandom);
		endcase
		load_settings(b, st, dp, g, pick_blend(), pick_blend());
	endtask

	initial begin
		int wait_cyc;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_in <= '0;
		block_start <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: plain pass-through
		send_sample(24'sh7FFFFF, 1'b1);
		send_sample(24'sh800000, 1'b0);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		drain();

		// zero delay taps the current sample; gain of minus one cancels it
		load_settings(12'd0, 32'h0, 16'h0, 16'h8000, 16'd32768, 16'd32768);
		send_sample(24'sh7FFFFF, 1'b1);
		send_sample(24'sh800000, 1'b0);
		send_sample(24'shAAAAAA, 1'b0);
		drain();

		// blends above one clamp to one; doubled input clips
		load_settings(12'd0, 32'h0, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		send_sample(24'sh7FFFFF, 1'b1);
		send_sample(24'sh800000, 1'b0);
		send_sample(24'sh555555, 1'b0);
		drain();

		// full-depth LFO in quarter turns, taps reaching before block start
		load_settings(12'd40, 32'h4000_0000, 16'hFFFF, 16'sd20000, 16'd32768, 16'd16384);
		for (int i = 0; i < 12; i++) begin
			send_sample(rand_sample(), i == 0 || i == 9);
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			stall_mode = ph % 3;
			gap_max = (ph % 4 == 1) ? 0 : $urandom_range(2, 8);
			random_settings();
			for (int n = 0; n < 150; n++) begin
				if (ph == 3 && n == 75) begin
					drain();
				end
				send_sample(rand_sample(), n == 0 || $urandom_range(0, 39) == 0);
			end
			drain();
		end

		// one long block: the LFO sweeps the delay up and back down, from beyond the block position to within it
		stall_mode = 0;
		gap_max = 0;
		load_settings(12'd160, 32'd23860929, 16'hFFFF, 16'($urandom), 16'd32768, 16'd32768);
		for (int n = 0; n < 180; n++) begin
			send_sample(rand_sample(), n == 0);
		end

		in_valid <= 1'b0;
		for (wait_cyc = 0; wait_cyc < 2000 && sb.pending() != 0; wait_cyc++) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d transactions never came out", sb.pending()));
		end

		$display("%0d samples over %0d register settings: %0d tapped (%s %0d)",
			sb.n_in, n_settings, sb.n_wet, "longest delay", sb.max_dly);
		$display("%0d dry with tap before block start, %0d clipped, %0d outputs checked, %0d bad",
			sb.n_early, sb.n_sat, sb.n_out, sb.errors);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
